[src/newton_square_root_unit_macros.svh]
// Assertion macros shared by the newton square root checker.
// Depends on nothing; callers provide clk and arst_n in scope.
`ifndef NEWTON_SQUARE_ROOT_UNIT_MACROS_SVH
`define NEWTON_SQUARE_ROOT_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NSR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NSR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/nsr_pkg.sv]
// Shared constants, status codes and helpers for the newton square root unit.
// No dependencies.
package nsr_pkg;

	localparam int VALUE_W       = 32;
	localparam int ROOT_W        = 24;
	localparam int TOL_W         = 17;
	// guesses stay below 2**31 for any fraction width in range
	localparam int GUESS_W       = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int MAX_ITER_DEF  = 64;
	localparam logic [TOL_W-1:0] TOL_RESET = 17'd1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_NEG   = 2'd1,
		STATUS_LIMIT = 2'd2
	} status_t;

	// clamp a guess to the root field
	function automatic logic [ROOT_W-1:0] sat_root(input logic [GUESS_W-1:0] g);
		logic [ROOT_W-1:0] r;
		if (|g[GUESS_W-1:ROOT_W]) begin
			r = {ROOT_W{1'b1}};
		end else begin
			r = g[ROOT_W-1:0];
		end
		return r;
	endfunction

endpackage

[src/newton_square_root_unit.sv]
// Newton-Raphson square root of a signed fixed-point operand.
// Depends on nsr_pkg.
//
// Usage:
//   Command channel: an operand beat is taken on a rising edge with start high
//   and busy low. Exactly one result beat follows: done is high for one cycle
//   with root and status valid. The receiver cannot stall; the result is gone
//   after that cycle.
//   Config channel: cfg_valid/cfg_ready write the tolerance; cfg_ready is low
//   while busy.
// Sequencing:
//   Negative, zero and exactly-one operands answer in the cycle after they are
//   taken, and busy stays low, so another beat may follow at once.
//   Other operands run k Newton steps, where k is 1 to MAX_ITER. Each step
//   is an MW-bit restoring division (MW = 31+FRAC_BITS) on one shared
//   subtract/compare unit, then an add state and a compare state.
//   busy is high for the whole item.
// Reset: asynchronous, clears the sequencer, drops busy and done, and sets the
//   tolerance to 1 LSB.
module newton_square_root_unit #(
	parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF,
	parameter int MAX_ITER  = nsr_pkg::MAX_ITER_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [nsr_pkg::VALUE_W-1:0] value,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [nsr_pkg::TOL_W-1:0]          cfg_data,
	output logic                              done,
	output logic [nsr_pkg::ROOT_W-1:0]         root,
	output logic [1:0]                        status
);

	localparam int GW = nsr_pkg::GUESS_W;
	localparam int VW = nsr_pkg::VALUE_W;
	localparam int TW = nsr_pkg::TOL_W;
	localparam int MW = VW - 1 + FRAC_BITS;
	localparam int IW = $clog2(MAX_ITER + 1);
	localparam int CW = $clog2(MW);
	localparam logic [GW-1:0] ONE = {{(GW-1){1'b0}}, 1'b1} << FRAC_BITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_SUM,
		ST_CHECK
	} state_t;

	state_t           state_q;
	logic             busy_q;
	logic             done_q;
	logic [nsr_pkg::ROOT_W-1:0] root_q;
	nsr_pkg::status_t status_q;
	logic [TW-1:0]    tol_q;
	logic [MW-1:0]    m_q;
	logic [MW-1:0]    dvd_q;
	logic [GW-1:0]    rem_q;
	logic [GW-1:0]    last_q;
	logic [GW-1:0]    next_q;
	logic [IW-1:0]    iter_q;
	logic [CW-1:0]    cnt_q;

	logic [GW-1:0]    divisor;
	logic [GW:0]      rem_sh;
	logic             fits;
	logic [GW:0]      rem_nx;
	logic [MW:0]      sum_w;
	logic [GW-1:0]    diff_w;
	logic             conv;
	logic             at_limit;

	// shared divide step: one quotient bit a cycle
	always_comb begin
		divisor = (last_q == '0) ? {{(GW-1){1'b0}}, 1'b1} : last_q;
		rem_sh  = {rem_q, dvd_q[MW-1]};
		fits    = rem_sh >= {1'b0, divisor};
		rem_nx  = fits ? (rem_sh - {1'b0, divisor}) : rem_sh;
	end

	// guess update and convergence test
	always_comb begin
		sum_w    = {1'b0, dvd_q} + {{(MW+1-GW){1'b0}}, last_q};
		diff_w   = (last_q > next_q) ? (last_q - next_q) : (next_q - last_q);
		conv     = diff_w < {{(GW-TW){1'b0}}, tol_q};
		at_limit = iter_q >= IW'(MAX_ITER);
	end

	// tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= nsr_pkg::TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= cfg_data;
		end
	end

	// sequencer, datapath and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			root_q   <= '0;
			status_q <= nsr_pkg::STATUS_OK;
			m_q      <= '0;
			dvd_q    <= '0;
			rem_q    <= '0;
			last_q   <= '0;
			next_q   <= '0;
			iter_q   <= '0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (value[VW-1]) begin
							done_q   <= 1'b1;
							root_q   <= '0;
							status_q <= nsr_pkg::STATUS_NEG;
						end else if (value == '0) begin
							done_q   <= 1'b1;
							root_q   <= '0;
							status_q <= nsr_pkg::STATUS_OK;
						end else if ($unsigned(value) == ONE) begin
							done_q   <= 1'b1;
							root_q   <= nsr_pkg::sat_root(ONE);
							status_q <= nsr_pkg::STATUS_OK;
						end else begin
							m_q     <= {value[VW-2:0], {FRAC_BITS{1'b0}}};
							dvd_q   <= {value[VW-2:0], {FRAC_BITS{1'b0}}};
							rem_q   <= '0;
							last_q  <= ONE;
							iter_q  <= '0;
							cnt_q   <= CW'(MW - 1);
							busy_q  <= 1'b1;
							state_q <= ST_DIVIDE;
						end
					end
				end
				ST_DIVIDE: begin
					rem_q <= rem_nx[GW-1:0];
					dvd_q <= {dvd_q[MW-2:0], fits};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					// quotient now sits in dvd_q
					next_q  <= sum_w[GW:1];
					iter_q  <= iter_q + 1'b1;
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (conv || at_limit) begin
						done_q   <= 1'b1;
						root_q   <= nsr_pkg::sat_root(next_q);
						status_q <= conv ? nsr_pkg::STATUS_OK : nsr_pkg::STATUS_LIMIT;
						busy_q   <= 1'b0;
						state_q  <= ST_IDLE;
					end else begin
						last_q  <= next_q;
						dvd_q   <= m_q;
						rem_q   <= '0;
						cnt_q   <= CW'(MW - 1);
						state_q <= ST_DIVIDE;
					end
				end
				default: begin
					busy_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = busy_q;
	assign cfg_ready = !busy_q;
	assign done      = done_q;
	assign root      = root_q;
	assign status    = status_q;

endmodule

[src/nsr_checker.sv]
// Port-level checks for the newton square root unit, bound to its top level.
// Depends on nsr_pkg and newton_square_root_unit_macros.svh.
`include "newton_square_root_unit_macros.svh"

module nsr_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic signed [nsr_pkg::VALUE_W-1:0] value,
	input logic                               cfg_valid,
	input logic                               cfg_ready,
	input logic [nsr_pkg::TOL_W-1:0]          cfg_data,
	input logic                               done,
	input logic [nsr_pkg::ROOT_W-1:0]         root,
	input logic [1:0]                         status
);

	// negative operand answers on the next cycle
	`NSR_ASSERT_NEXT(a_neg_fast, start && !busy && value[nsr_pkg::VALUE_W-1], done && status == nsr_pkg::STATUS_NEG, "negative operand not flagged next cycle")

	// zero operand answers zero on the next cycle
	`NSR_ASSERT_NEXT(a_zero_fast, start && !busy && value == '0, done && root == '0 && status == nsr_pkg::STATUS_OK, "zero operand not answered next cycle")

	// an invalid result carries a zero root
	`NSR_ASSERT_SAME(a_neg_root, done && status == nsr_pkg::STATUS_NEG, root == '0, "negative status with nonzero root")

	// leaving busy always comes with a result beat
	`NSR_ASSERT_SAME(a_busy_end, $fell(busy), done, "busy dropped without a result")

	// a result beat never overlaps a busy cycle
	`NSR_ASSERT_SAME(a_done_idle, done, !busy, "result shown while busy")

endmodule

bind newton_square_root_unit nsr_checker u_nsr_checker (.*);

[bench/tb.sv]
// Self-checking bench for newton_square_root_unit: directed table, then random phases.
// Depends on nsr_pkg and newton_square_root_unit; checks results vs. typed rows or Heron model.
module tb;

	localparam int FRAC = nsr_pkg::FRAC_BITS_DEF;
	localparam int ITER_CAP = nsr_pkg::MAX_ITER_DEF;
	localparam logic [63:0] ONE_Q = 64'd1 << FRAC;
	localparam logic [nsr_pkg::TOL_W-1:0] TOL_MAX = {nsr_pkg::TOL_W{1'b1}};
	localparam logic [nsr_pkg::TOL_W-1:0] TOL_NONE = '0;

	typedef struct packed {
		logic [nsr_pkg::ROOT_W-1:0] root;
		nsr_pkg::status_t           status;
	} root_beat_t;

	typedef struct {
		logic [nsr_pkg::TOL_W-1:0]   tol;
		logic [nsr_pkg::VALUE_W-1:0] value;
		bit                          typed;
		root_beat_t                  want;
	} dir_row_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               start = 1'b0;
	logic signed [nsr_pkg::VALUE_W-1:0] value = '0;
	logic                               cfg_valid = 1'b0;
	logic [nsr_pkg::TOL_W-1:0]          cfg_data = '0;
	logic                               busy;
	logic                               cfg_ready;
	logic                               done;
	logic [nsr_pkg::ROOT_W-1:0]         root;
	logic [1:0]                         status;

	root_beat_t                roots_due[$];
	logic [nsr_pkg::TOL_W-1:0] tol_now = nsr_pkg::TOL_RESET;
	bit                        steady = 1'b0;
	int                        err_cnt = 0;
	int                        operands_sent = 0;
	int                        tol_writes = 0;
	int                        roots_seen = 0;
	int                        cap_seen = 0;
	int                        neg_seen = 0;

	// directed plan: typed rows are read straight off the spec, others use the predictor
	dir_row_t plan [24] = '{
		'{17'd1, 32'h0000_0000, 1'b1, '{24'h000000, nsr_pkg::STATUS_OK}},
		'{17'd1, 32'h0001_0000, 1'b1, '{24'h010000, nsr_pkg::STATUS_OK}},
		'{17'd1, 32'h8000_0000, 1'b1, '{24'h000000, nsr_pkg::STATUS_NEG}},
		'{17'd1, 32'hFFFF_FFFF, 1'b1, '{24'h000000, nsr_pkg::STATUS_NEG}},
		'{17'd1, 32'hFFFF_0000, 1'b1, '{24'h000000, nsr_pkg::STATUS_NEG}},
		'{17'd1, 32'h7FFF_FFFF, 1'b0, '{24'h000000, nsr_pkg::STATUS_OK}},
		'{17'd1, 32'h0000_0001, 1'b0, '{24'h000000, nsr_pkg::STATUS_OK}},
		'{17'd1, 32'h0000_FFFF, 1'b0, '{24'h000000, nsr_pkg::STATUS_OK}},
		'{17'd1, 32'h0001_0001, 1'b0, '{24'h000000, nsr_pkg::STATUS_OK}},
		'{17'd1, 32'h0004_0000, 1'b0, '{24'h000000, nsr_pkg::STATUS_OK}},
		'{17'd1, 32'h0000_FFFE, 1'b0, '{24'h000000, nsr_pkg::STATUS_OK}},
		'{17'd1, 32'h0001_0002, 1'b0, '{24'h000000, nsr_pkg::STATUS_OK}},
		'{17'd1, 32'h5555_AAAA, 1'b0, '{24'h000000, nsr_pkg::STATUS_OK}},
		'{TOL_NONE, 32'h0004_0000, 1'b0, '{24'h000000, nsr_pkg::STATUS_OK}},
		'{TOL_NONE, 32'h0000_0000, 1'b1, '{24'h000000, nsr_pkg::STATUS_OK}},
		'{TOL_NONE, 32'h0001_0000, 1'b1, '{24'h010000, nsr_pkg::STATUS_OK}},
		'{TOL_NONE, 32'h0000_0001, 1'b0, '{24'h000000, nsr_pkg::STATUS_OK}},
		'{TOL_MAX, 32'h7FFF_FFFF, 1'b0, '{24'h000000, nsr_pkg::STATUS_OK}},
		'{TOL_MAX, 32'h0002_0000, 1'b0, '{24'h000000, nsr_pkg::STATUS_OK}},
		'{TOL_MAX, 32'h0000_0001, 1'b0, '{24'h000000, nsr_pkg::STATUS_OK}},
		'{17'h10000, 32'h0009_0000, 1'b0, '{24'h000000, nsr_pkg::STATUS_OK}},
		'{17'h10000, 32'h8000_0001, 1'b1, '{24'h000000, nsr_pkg::STATUS_NEG}},
		'{17'h10000, 32'h0003_0000, 1'b0, '{24'h000000, nsr_pkg::STATUS_OK}},
		'{17'd1, 32'h0000_0003, 1'b0, '{24'h000000, nsr_pkg::STATUS_OK}}
	};

	newton_square_root_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.done      (done),
		.root      (root),
		.status    (status)
	);

	// 10-unit clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Heron iteration from a 1.0 guess, truncating divide, stop on small step or cap
	function automatic root_beat_t heron_root(input logic [nsr_pkg::VALUE_W-1:0] v,
			input logic [nsr_pkg::TOL_W-1:0] tol);
		root_beat_t  res;
		logic [63:0] m;
		logic [63:0] g;
		logic [63:0] g_nxt;
		logic [63:0] step;
		int          n;
		res.root = '0;
		res.status = nsr_pkg::STATUS_OK;
		if (v[nsr_pkg::VALUE_W-1]) begin
			res.status = nsr_pkg::STATUS_NEG;
			return res;
		end
		if (v == '0) begin
			return res;
		end
		if (v == ONE_Q[nsr_pkg::VALUE_W-1:0]) begin
			res.root = ONE_Q[nsr_pkg::ROOT_W-1:0];
			return res;
		end
		m = {32'd0, v} << FRAC;
		g = ONE_Q;
		g_nxt = (g + m / g) >> 1;
		n = 1;
		forever begin
			step = (g > g_nxt) ? g - g_nxt : g_nxt - g;
			if (step < {47'd0, tol}) begin
				break;
			end
			if (n >= ITER_CAP) begin
				res.status = nsr_pkg::STATUS_LIMIT;
				break;
			end
			g = g_nxt;
			g_nxt = (g + m / ((g == 0) ? 64'd1 : g)) >> 1;
			n++;
		end
		res.root = (g_nxt > 64'hFF_FFFF) ? {nsr_pkg::ROOT_W{1'b1}}
			: g_nxt[nsr_pkg::ROOT_W-1:0];
		return res;
	endfunction

	// random operand: negatives, specials, small values, near-squares, full range
	function automatic logic [nsr_pkg::VALUE_W-1:0] pick_operand();
		int unsigned sel;
		logic [63:0] k;
		logic [63:0] sq;
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			return {1'b1, 31'($urandom)};
		end else if (sel < 12) begin
			case ($urandom_range(0, 2))
				0: return '0;
				1: return ONE_Q[nsr_pkg::VALUE_W-1:0];
				default: return '1;
			endcase
		end else if (sel < 27) begin
			return $urandom_range(1, 32'h1_FFFF);
		end else if (sel < 40) begin
			k = 64'($urandom_range(1, 32'hB5_04F3));
			sq = ((k * k) >> FRAC) + 64'($urandom_range(0, 2));
			if (sq != 0) begin
				sq = sq - 1;
			end
			return {1'b0, sq[30:0]};
		end
		return {1'b0, 31'($urandom)};
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
		err_cnt++;
	endtask

	// result monitor: every done beat is checked against the oldest expectation
	always @(posedge clk) begin
		root_beat_t e;
		if (arst_n && done) begin
			roots_seen++;
			if (status == nsr_pkg::STATUS_LIMIT) begin
				cap_seen++;
			end
			if (roots_due.size() == 0) begin
				flag_mismatch("unexpected result beat", {8'd0, root}, 32'd0);
			end else begin
				e = roots_due.pop_front();
				if (root !== e.root) begin
					flag_mismatch("root", {8'd0, root}, {8'd0, e.root});
				end
				if (status !== e.status) begin
					flag_mismatch("status", {30'd0, status}, {30'd0, e.status});
				end
			end
		end
	end

	// present one operand; the expectation is queued at the accepting edge
	task automatic send_operand(input logic [nsr_pkg::VALUE_W-1:0] v, input bit typed,
			input root_beat_t typed_want);
		root_beat_t want;
		want = typed ? typed_want : heron_root(v, tol_now);
		if (!steady && $urandom_range(0, 99) < 11) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 40);
		end
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
		roots_due.push_back(want);
		operands_sent++;
		if (v[nsr_pkg::VALUE_W-1]) begin
			neg_seen++;
		end
	endtask

	// drop start and wait for every outstanding result
	task automatic drain_roots();
		start <= 1'b0;
		while (roots_due.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// tolerance write, only issued with the unit idle
	task automatic write_tolerance(input logic [nsr_pkg::TOL_W-1:0] t);
		drain_roots();
		if (!steady) begin
			while ($urandom_range(0, 99) < 11) @(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_data <= t;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tol_now = t;
		tol_writes++;
	endtask

	// main sequence
	initial begin
		logic [nsr_pkg::TOL_W-1:0] t;
		int                        n_ops;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, first rows run on the reset tolerance
		foreach (plan[i]) begin
			if (plan[i].tol != tol_now) begin
				write_tolerance(plan[i].tol);
			end
			send_operand(plan[i].value, plan[i].typed, plan[i].want);
		end

		// random phases, each under its own tolerance
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: t = 17'd1;
				1: t = TOL_MAX;
				2: t = TOL_NONE;
				3: t = 17'h10000;
				4: t = nsr_pkg::TOL_W'($urandom_range(1, 64));
				5: t = nsr_pkg::TOL_W'($urandom_range(1, 32'h1_FFFF));
				6: t = 17'd2;
				default: t = nsr_pkg::TOL_W'($urandom_range(1, 1024));
			endcase
			// zero tolerance runs every iterating operand to the cap, so keep it short
			n_ops = (t == TOL_NONE) ? 15 : 50;
			write_tolerance(t);
			steady = (ph == 4);
			repeat (n_ops) begin
				send_operand(pick_operand(), 1'b0, '0);
			end
		end
		steady = 1'b0;

		drain_roots();
		repeat (200) @(posedge clk);
		$display("Ran %0d operands (%0d negative) over %0d tolerance writes;",
			operands_sent, neg_seen, tol_writes);
		$display("%0d results checked, %0d of them at the iteration cap.",
			roots_seen, cap_seen);
		if (err_cnt == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#60000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
